/* design/t4t_pkg.sv */
// t4t_pkg: types and fixed codes of the type 4 tag responder
// no dependencies; imported by type4_tag_apdu_responder

package t4t_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_word;
    typedef logic [5:0]  t_size;
    typedef logic [1:0]  t_cfg_idx;

    // register indexes of the configuration port
    localparam t_cfg_idx CFG_CAP_SIZE  = 2'd0;
    localparam t_cfg_idx CFG_NDEF_SIZE = 2'd1;
    localparam t_cfg_idx CFG_CAP_ID    = 2'd2;
    localparam t_cfg_idx CFG_NDEF_ID   = 2'd3;

    // register reset values
    localparam t_size RST_CAP_SIZE  = 6'd15;
    localparam t_size RST_NDEF_SIZE = 6'd49;
    localparam t_word RST_CAP_ID    = 16'hE103;
    localparam t_word RST_NDEF_ID   = 16'hE104;

    // longest data part of one response
    localparam int MAX_DATA = 62;

    // action codes
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMMAND = 1'b1;

    // selection codes
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_CAP  = 2'd1;
    localparam logic [1:0] SEL_NDEF = 2'd2;

    // command header codes
    localparam t_byte CLA_ISO      = 8'h00;
    localparam t_byte INS_SELECT   = 8'hA4;
    localparam t_byte INS_READ     = 8'hB0;
    localparam t_byte P1_BY_NAME   = 8'h04;
    localparam t_byte P1_BY_ID     = 8'h00;
    localparam t_byte P2_BY_NAME   = 8'h00;
    localparam t_byte P2_FIRST     = 8'h0C;

    // status words
    localparam t_byte SW1_OK       = 8'h90;
    localparam t_byte SW2_OK       = 8'h00;
    localparam t_byte SW1_NOT_FND  = 8'h6A;
    localparam t_byte SW2_NOT_FND  = 8'h82;
    localparam t_byte SW1_BAD_INS  = 8'h68;
    localparam t_byte SW2_BAD_INS  = 8'h00;

endpackage

/* design/type4_tag_apdu_responder.sv */
// type4_tag_apdu_responder: type 4 tag card-emulation responder, top level
// holds the file store, the configuration registers and the response sequencer
// depends on t4t_pkg

// A request either loads one byte into the capability or NDEF file (accepted
// without a response) or presents a command header. A command is answered one
// byte per response beat: data bytes of a read binary, then the two status
// bytes, the second one flagged last. A read binary returns n data bytes, 0 to
// 62; a select or an error returns only the status bytes. The pace is one byte
// per cycle while the sink is ready, set by the address counter that steps
// the registered read port of the file store; the input stays not ready until
// the last status byte has been loaded into the output register. Output stalls
// hold the sequencer without losing bytes.

module type4_tag_apdu_responder #(
    parameter int FILE_BYTES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration writes
    input  logic              i_cfg_we,
    input  t4t_pkg::t_cfg_idx i_cfg_idx,
    input  t4t_pkg::t_word    i_cfg_data,
    // request channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_action,
    input  t4t_pkg::t_byte    i_cls_byte,
    input  t4t_pkg::t_byte    i_ins_byte,
    input  t4t_pkg::t_byte    i_p1_byte,
    input  t4t_pkg::t_byte    i_p2_byte,
    input  t4t_pkg::t_byte    i_p3_byte,
    input  t4t_pkg::t_byte    i_id_high,
    input  t4t_pkg::t_byte    i_id_low,
    input  logic              i_load_file,
    input  t4t_pkg::t_size    i_load_addr,
    input  t4t_pkg::t_byte    i_load_value,
    // response channel
    output logic              o_valid,
    input  logic              i_ready,
    output t4t_pkg::t_byte    o_resp_byte,
    output logic              o_last,
    output logic              o_delivered
);
    import t4t_pkg::*;

    localparam int DEPTH    = 2 * FILE_BYTES;
    localparam int AW       = $clog2(DEPTH);
    localparam int SIZE_CAP = (FILE_BYTES < MAX_DATA) ? FILE_BYTES : MAX_DATA;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DATA = 2'd1;
    localparam logic [1:0] S_SW1  = 2'd2;
    localparam logic [1:0] S_SW2  = 2'd3;

    // configuration registers
    t_size r_cap_size;
    t_size r_ndef_size;
    t_word r_cap_id;
    t_word r_ndef_id;

    // file store
    t_byte r_mem [0:DEPTH-1];
    t_byte r_rd_data;

    // sequencer
    logic [1:0]    r_state,  n_state;
    logic [1:0]    r_sel,    n_sel;
    logic [AW-1:0] r_addr,   n_addr;
    t_size         r_cnt,    n_cnt;
    t_byte         r_sw1,    n_sw1;
    t_byte         r_sw2,    n_sw2;
    logic          r_dlv,    n_dlv;

    // output register
    logic  r_out_valid, n_out_valid;
    t_byte r_out_byte,  n_out_byte;
    logic  r_out_last,  n_out_last;
    logic  r_out_dlv,   n_out_dlv;

    logic          accept;
    logic          out_free;
    logic          is_by_name;
    logic          is_by_id;
    logic          is_read;
    t_word         file_id;
    t_word         offset;
    t_size         raw_size;
    t_size         eff_size;
    t_size         remain;
    t_size         n_bytes;
    logic          reach_end;
    logic [AW-1:0] base;
    logic [AW-1:0] wr_addr;
    logic          wr_en;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    assign is_by_name = (i_cls_byte == CLA_ISO) && (i_ins_byte == INS_SELECT)
                        && (i_p1_byte == P1_BY_NAME) && (i_p2_byte == P2_BY_NAME);
    assign is_by_id   = (i_cls_byte == CLA_ISO) && (i_ins_byte == INS_SELECT)
                        && (i_p1_byte == P1_BY_ID) && (i_p2_byte == P2_FIRST);
    assign is_read    = (i_cls_byte == CLA_ISO) && (i_ins_byte == INS_READ);
    assign file_id    = {i_id_high, i_id_low};
    assign offset     = {i_p1_byte, i_p2_byte};

    // effective file size, saturated at the store and at the data limit
    assign raw_size  = (r_sel == SEL_NDEF) ? r_ndef_size : r_cap_size;
    assign eff_size  = (raw_size > 6'(SIZE_CAP)) ? 6'(SIZE_CAP) : raw_size;
    assign remain    = eff_size - i_p2_byte[5:0];
    assign n_bytes   = (i_p3_byte < {2'b00, remain}) ? i_p3_byte[5:0] : remain;
    assign reach_end = (i_p3_byte >= {2'b00, remain});
    assign base      = (r_sel == SEL_NDEF) ? AW'(FILE_BYTES) : '0;

    // load path
    assign wr_en   = accept && (i_action == ACT_LOAD)
                     && ({1'b0, i_load_addr} < 7'(FILE_BYTES));
    assign wr_addr = (i_load_file ? AW'(FILE_BYTES) : '0) + AW'(i_load_addr);

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_sw1       = r_sw1;
        n_sw2       = r_sw2;
        n_dlv       = r_dlv;
        n_out_valid = r_out_valid && !i_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_dlv   = r_out_dlv;

        case (r_state)
            S_IDLE: begin
                if (accept && (i_action == ACT_COMMAND)) begin
                    n_state = S_SW1;
                    n_dlv   = 1'b0;
                    n_sw1   = SW1_OK;
                    n_sw2   = SW2_OK;
                    if (is_by_name) begin
                        n_sw1 = SW1_OK;
                    end else if (is_by_id) begin
                        if (file_id == r_cap_id) begin
                            n_sel = SEL_CAP;
                        end else if (file_id == r_ndef_id) begin
                            n_sel = SEL_NDEF;
                        end
                    end else if (is_read) begin
                        if ((r_sel == SEL_NONE) || (offset >= 16'(eff_size))) begin
                            n_sw1 = SW1_NOT_FND;
                            n_sw2 = SW2_NOT_FND;
                        end else begin
                            n_dlv  = (r_sel == SEL_NDEF) && reach_end;
                            n_addr = base + AW'(i_p2_byte[5:0]);
                            n_cnt  = n_bytes;
                            if (n_bytes != '0) begin
                                n_state = S_DATA;
                            end
                        end
                    end else begin
                        n_sw1 = SW1_BAD_INS;
                        n_sw2 = SW2_BAD_INS;
                    end
                end
            end
            S_DATA: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_rd_data;
                    n_out_last  = 1'b0;
                    n_out_dlv   = r_dlv;
                    n_addr      = r_addr + AW'(1);
                    n_cnt       = r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        n_state = S_SW1;
                    end
                end
            end
            S_SW1: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_sw1;
                    n_out_last  = 1'b0;
                    n_out_dlv   = r_dlv;
                    n_state     = S_SW2;
                end
            end
            S_SW2: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_sw2;
                    n_out_last  = 1'b1;
                    n_out_dlv   = r_dlv;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // store write and registered read at the next address
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_load_value;
        end
        r_rd_data <= r_mem[n_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= SEL_NONE;
            r_out_valid <= 1'b0;
            r_cap_size  <= RST_CAP_SIZE;
            r_ndef_size <= RST_NDEF_SIZE;
            r_cap_id    <= RST_CAP_ID;
            r_ndef_id   <= RST_NDEF_ID;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAP_SIZE:  r_cap_size  <= i_cfg_data[5:0];
                    CFG_NDEF_SIZE: r_ndef_size <= i_cfg_data[5:0];
                    CFG_CAP_ID:    r_cap_id    <= i_cfg_data;
                    CFG_NDEF_ID:   r_ndef_id   <= i_cfg_data;
                    default: begin
                        r_cap_id <= r_cap_id;
                    end
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_cnt      <= n_cnt;
        r_sw1      <= n_sw1;
        r_sw2      <= n_sw2;
        r_dlv      <= n_dlv;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_dlv  <= n_out_dlv;
    end

    assign o_valid     = r_out_valid;
    assign o_resp_byte = r_out_byte;
    assign o_last      = r_out_last;
    assign o_delivered = r_out_dlv;

endmodule

/* tb/tb_type4_tag_apdu_responder.sv */
`timescale 1ns / 100ps
// tb_type4_tag_apdu_responder: self-checking testbench of the type 4 tag responder
// sends loads and command headers with random gaps and sink stalls, predicts every
// response byte in-bench and compares; depends on t4t_pkg and type4_tag_apdu_responder

module tb_type4_tag_apdu_responder;
    import t4t_pkg::*;

    localparam int FILE_BYTES     = 64;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct {
        logic  action;
        t_byte cls;
        t_byte ins;
        t_byte p1;
        t_byte p2;
        t_byte p3;
        t_byte id_hi;
        t_byte id_lo;
        logic  load_file;
        t_size load_addr;
        t_byte load_value;
    } t_request;

    typedef struct {
        t_byte resp;
        logic  last;
        logic  delivered;
    } t_beat;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    t_cfg_idx   cfg_idx = CFG_CAP_SIZE;
    t_word      cfg_data = '0;
    logic       req_valid = 1'b0;
    logic       req_ready;
    logic       req_action = ACT_LOAD;
    t_byte      req_cls = '0;
    t_byte      req_ins = '0;
    t_byte      req_p1 = '0;
    t_byte      req_p2 = '0;
    t_byte      req_p3 = '0;
    t_byte      req_id_hi = '0;
    t_byte      req_id_lo = '0;
    logic       req_load_file = 1'b0;
    t_size      req_load_addr = '0;
    t_byte      req_load_value = '0;
    logic       rsp_valid;
    logic       rsp_ready = 1'b0;
    t_byte      rsp_byte;
    logic       rsp_last;
    logic       rsp_delivered;

    // in-bench copy of the responder state
    t_size      m_cap_size  = RST_CAP_SIZE;
    t_size      m_ndef_size = RST_NDEF_SIZE;
    t_word      m_cap_id    = RST_CAP_ID;
    t_word      m_ndef_id   = RST_NDEF_ID;
    logic [1:0] m_sel       = SEL_NONE;
    t_byte      m_store [0:2*FILE_BYTES-1];

    t_beat      exp_beats[$];
    int         errors = 0;
    int         n_requests = 0;
    int         n_beats = 0;
    int         n_settings = 0;
    int         idle_cycles = 0;
    int         tx_gap_pct = 0;
    int         rx_stall_pct = 0;
    int         stall_left = 0;

    type4_tag_apdu_responder #(.FILE_BYTES(FILE_BYTES)) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_valid      (req_valid),
        .o_ready      (req_ready),
        .i_action     (req_action),
        .i_cls_byte   (req_cls),
        .i_ins_byte   (req_ins),
        .i_p1_byte    (req_p1),
        .i_p2_byte    (req_p2),
        .i_p3_byte    (req_p3),
        .i_id_high    (req_id_hi),
        .i_id_low     (req_id_lo),
        .i_load_file  (req_load_file),
        .i_load_addr  (req_load_addr),
        .i_load_value (req_load_value),
        .o_valid      (rsp_valid),
        .i_ready      (rsp_ready),
        .o_resp_byte  (rsp_byte),
        .o_last       (rsp_last),
        .o_delivered  (rsp_delivered)
    );

    always #6 clk = ~clk;

    // ---------------------------------------------------------------- prediction

    function automatic int usable_size(t_size s);
        int n;
        n = int'(s);
        if (n > FILE_BYTES) n = FILE_BYTES;
        if (n > MAX_DATA) n = MAX_DATA;
        return n;
    endfunction

    function automatic void push_status(t_byte sw1, t_byte sw2, logic dlv);
        exp_beats.push_back('{sw1, 1'b0, dlv});
        exp_beats.push_back('{sw2, 1'b1, dlv});
    endfunction

    task automatic predict_answer(input t_request r);
        int   size;
        int   base;
        int   offset;
        int   n;
        logic dlv;
        t_word id;
        id = {r.id_hi, r.id_lo};
        if (r.action == ACT_LOAD) begin
            if (int'(r.load_addr) < FILE_BYTES)
                m_store[int'(r.load_file) * FILE_BYTES + int'(r.load_addr)] = r.load_value;
        end else if (r.cls == CLA_ISO && r.ins == INS_SELECT && r.p1 == P1_BY_NAME
                     && r.p2 == P2_BY_NAME) begin
            push_status(SW1_OK, SW2_OK, 1'b0);
        end else if (r.cls == CLA_ISO && r.ins == INS_SELECT && r.p1 == P1_BY_ID
                     && r.p2 == P2_FIRST) begin
            if (id == m_cap_id)
                m_sel = SEL_CAP;
            else if (id == m_ndef_id)
                m_sel = SEL_NDEF;
            push_status(SW1_OK, SW2_OK, 1'b0);
        end else if (r.cls == CLA_ISO && r.ins == INS_READ) begin
            offset = int'({r.p1, r.p2});
            size = 0;
            base = 0;
            if (m_sel == SEL_CAP) begin
                size = usable_size(m_cap_size);
            end else if (m_sel == SEL_NDEF) begin
                size = usable_size(m_ndef_size);
                base = FILE_BYTES;
            end
            if (m_sel == SEL_NONE || offset >= size) begin
                push_status(SW1_NOT_FND, SW2_NOT_FND, 1'b0);
            end else begin
                n = int'(r.p3);
                if (offset + n > size) n = size - offset;
                dlv = (m_sel == SEL_NDEF) && (offset + n >= size);
                for (int i = 0; i < n; i++)
                    exp_beats.push_back('{m_store[base + offset + i], 1'b0, dlv});
                push_status(SW1_OK, SW2_OK, dlv);
            end
        end else begin
            push_status(SW1_BAD_INS, SW2_BAD_INS, 1'b0);
        end
    endtask

    // ---------------------------------------------------------------- request builders

    function automatic t_request any_request();
        t_request r;
        r.action     = 1'($urandom_range(1));
        r.cls        = t_byte'($urandom);
        r.ins        = t_byte'($urandom);
        r.p1         = t_byte'($urandom);
        r.p2         = t_byte'($urandom);
        r.p3         = t_byte'($urandom);
        r.id_hi      = t_byte'($urandom);
        r.id_lo      = t_byte'($urandom);
        r.load_file  = 1'($urandom_range(1));
        r.load_addr  = t_size'($urandom);
        r.load_value = t_byte'($urandom);
        return r;
    endfunction

    function automatic t_request command(t_byte cls, t_byte ins, t_byte p1, t_byte p2,
                                         t_byte p3);
        t_request r;
        r = any_request();
        r.action = ACT_COMMAND;
        r.cls    = cls;
        r.ins    = ins;
        r.p1     = p1;
        r.p2     = p2;
        r.p3     = p3;
        return r;
    endfunction

    function automatic t_request select_file(t_word id);
        t_request r;
        r = command(CLA_ISO, INS_SELECT, P1_BY_ID, P2_FIRST, t_byte'($urandom));
        {r.id_hi, r.id_lo} = id;
        return r;
    endfunction

    function automatic t_request select_name();
        return command(CLA_ISO, INS_SELECT, P1_BY_NAME, P2_BY_NAME, t_byte'($urandom));
    endfunction

    function automatic t_request read_binary(t_word offset, t_byte len);
        return command(CLA_ISO, INS_READ, offset[15:8], offset[7:0], len);
    endfunction

    function automatic t_request load_byte(logic file, t_size addr, t_byte value);
        t_request r;
        r = any_request();
        r.action     = ACT_LOAD;
        r.load_file  = file;
        r.load_addr  = addr;
        r.load_value = value;
        return r;
    endfunction

    // mostly short pauses, now and then a long one
    function automatic int pick_gap(int pct);
        if (int'($urandom_range(99)) >= pct) return 0;
        if ($urandom_range(99) < 85) return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic send_request(input t_request r);
        int gap;
        gap = pick_gap(tx_gap_pct);
        @(negedge clk);
        if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_action     = r.action;
        req_cls        = r.cls;
        req_ins        = r.ins;
        req_p1         = r.p1;
        req_p2         = r.p2;
        req_p3         = r.p3;
        req_id_hi      = r.id_hi;
        req_id_lo      = r.id_lo;
        req_load_file  = r.load_file;
        req_load_addr  = r.load_addr;
        req_load_value = r.load_value;
        req_valid      = 1'b1;
        do @(posedge clk); while (!req_ready);
        predict_answer(r);
        n_requests++;
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        req_valid = 1'b0;
        while (exp_beats.size() > 0) @(posedge clk);
    endtask

    // a load leaves no response behind, so also idle the bench before touching registers
    task automatic settle_idle();
        hold_until_drained();
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_word data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
        case (idx)
            CFG_CAP_SIZE:  m_cap_size  = data[5:0];
            CFG_NDEF_SIZE: m_ndef_size = data[5:0];
            CFG_CAP_ID:    m_cap_id    = data;
            CFG_NDEF_ID:   m_ndef_id   = data;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input t_word cap_size, input t_word ndef_size,
                                  input t_word cap_id, input t_word ndef_id);
        settle_idle();
        write_reg(CFG_CAP_SIZE, cap_size);
        write_reg(CFG_NDEF_SIZE, ndef_size);
        write_reg(CFG_CAP_ID, cap_id);
        write_reg(CFG_NDEF_ID, ndef_id);
        n_settings++;
    endtask

    // sink side: random stalls
    always @(negedge clk) begin
        if (stall_left == 0) stall_left = pick_gap(rx_stall_pct);
        if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
        end else begin
            rsp_ready = 1'b1;
        end
    end

    // ---------------------------------------------------------------- checking

    always @(posedge clk) begin : check_responses
        t_beat e;
        if (rst_n && rsp_valid && rsp_ready) begin
            n_beats++;
            if (exp_beats.size() == 0) begin
                $error("response byte %02h arrived with none expected", rsp_byte);
                errors++;
            end else begin
                e = exp_beats.pop_front();
                if (rsp_byte !== e.resp) begin
                    $error("resp_byte: expected %02h, got %02h", e.resp, rsp_byte);
                    errors++;
                end
                if (rsp_last !== e.last) begin
                    $error("last: expected %0b, got %0b", e.last, rsp_last);
                    errors++;
                end
                if (rsp_delivered !== e.delivered) begin
                    $error("delivered: expected %0b, got %0b", e.delivered, rsp_delivered);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d bytes outstanding",
                     idle_cycles, exp_beats.size());
            $display("tb_type4_tag_apdu_responder NOT OK");
            $finish;
        end
    end

    // ---------------------------------------------------------------- tests

    // every byte of both files gets a value before anything reads it
    task automatic load_files();
        for (int f = 0; f < 2; f++)
            for (int a = 0; a < FILE_BYTES; a++)
                send_request(load_byte(f[0], t_size'(a), t_byte'($urandom)));
    endtask

    task automatic test_no_selection();
        send_request(read_binary(16'h0000, 8'd4));
        send_request(select_file(16'h0000));
        send_request(read_binary(16'h0000, 8'd1));
    endtask

    task automatic test_select();
        send_request(select_name());
        send_request(select_file(RST_CAP_ID));
        send_request(select_name());
    endtask

    task automatic test_read_cap();
        send_request(read_binary(16'h0000, 8'd0));
        send_request(read_binary(16'h0000, 8'hFF));
        send_request(read_binary(16'd14, 8'd1));
        send_request(read_binary(16'd15, 8'd1));
        send_request(read_binary(16'hFFFF, 8'hFF));
    endtask

    task automatic test_read_ndef();
        send_request(select_file(RST_NDEF_ID));
        send_request(read_binary(16'h0000, 8'hFF));
        send_request(read_binary(16'd48, 8'd1));
        send_request(read_binary(16'd10, 8'd5));
        send_request(read_binary(16'h0000, 8'd48));
    endtask

    task automatic test_bad_header();
        send_request(command(8'h80, INS_READ, 8'h00, 8'h00, 8'h04));
        send_request(command(CLA_ISO, 8'hFF, 8'h00, 8'h00, 8'h00));
        send_request(command(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(command(CLA_ISO, INS_SELECT, P1_BY_NAME, P2_FIRST, 8'h00));
        send_request(command(CLA_ISO, INS_SELECT, 8'h01, P2_BY_NAME, 8'h00));
    endtask

    task automatic test_register_extremes();
        // empty capability file, oversized NDEF size, both identifiers equal
        write_all_regs(16'hFFC0, 16'hABFF, 16'hFFFF, 16'hFFFF);
        send_request(select_file(16'hFFFF));
        send_request(read_binary(16'h0000, 8'hFF));
        write_all_regs(16'h003E, 16'h0000, 16'h0000, 16'hFFFF);
        send_request(read_binary(16'd61, 8'hFF));
        send_request(select_file(16'hFFFF));
        send_request(read_binary(16'h0000, 8'h00));
        write_all_regs(16'h0001, 16'h003F, 16'h0000, 16'hFFFF);
        send_request(read_binary(16'h0000, 8'hFF));
        send_request(read_binary(16'd61, 8'd2));
        send_request(select_file(16'h0000));
        send_request(read_binary(16'h0000, 8'hFF));
    endtask

    task automatic random_registers();
        t_word sz [2];
        t_word id [2];
        for (int i = 0; i < 2; i++) begin
            case ($urandom_range(4))
                0: sz[i] = 16'd0;
                1: sz[i] = 16'd62;
                2: sz[i] = 16'd63;
                default: sz[i] = t_word'($urandom_range(1, 61));
            endcase
            sz[i][15:6] = 10'($urandom);
            id[i] = t_word'($urandom);
        end
        if ($urandom_range(5) == 0) id[1] = id[0];
        write_all_regs(sz[0], sz[1], id[0], id[1]);
    endtask

    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        t_request r;
        t_word    offset;
        t_byte    len;
        int       k;
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
        random_registers();
        for (int n = 0; n < count; n++) begin
            k = int'($urandom_range(99));
            if (k < 10) begin
                r = any_request();
                r.action = ACT_LOAD;
            end else if (k < 22) begin
                r = select_name();
            end else if (k < 45) begin
                case ($urandom_range(2))
                    0: r = select_file(m_cap_id);
                    1: r = select_file(m_ndef_id);
                    default: r = select_file(t_word'($urandom));
                endcase
            end else if (k < 90) begin
                if ($urandom_range(9) == 0) offset = t_word'($urandom);
                else offset = t_word'($urandom_range(63));
                k = int'($urandom_range(9));
                if (k < 7) len = t_byte'($urandom_range(20));
                else if (k < 9) len = t_byte'($urandom_range(70));
                else len = t_byte'($urandom);
                r = read_binary(offset, len);
            end else if (k < 95) begin
                // near misses on the select header
                r = command(CLA_ISO, INS_SELECT, t_byte'($urandom_range(5)),
                            t_byte'($urandom_range(15)), t_byte'($urandom));
            end else begin
                r = any_request();
                r.action = ACT_COMMAND;
            end
            if ($urandom_range(39) == 0) hold_until_drained();
            send_request(r);
        end
    endtask

    initial begin
        for (int i = 0; i < 2 * FILE_BYTES; i++) m_store[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tx_gap_pct   = 20;
        rx_stall_pct = 20;
        load_files();
        test_no_selection();
        test_select();
        test_read_cap();
        test_read_ndef();
        test_bad_header();
        test_register_extremes();

        test_random_traffic(20, 30, 30);
        test_random_traffic(20, 0, 0);
        test_random_traffic(20, 60, 60);
        test_random_traffic(20, 15, 70);
        test_random_traffic(20, 70, 10);

        hold_until_drained();
        repeat (80) @(posedge clk);

        $display("sent %0d requests (file loads, selects, reads, bad headers)", n_requests);
        $display("checked %0d response bytes over %0d register settings",
                 n_beats, n_settings);
        if (errors == 0) begin
            $display("tb_type4_tag_apdu_responder OK");
        end else begin
            $display("tb_type4_tag_apdu_responder NOT OK");
        end
        $finish;
    end

endmodule
